>>> rtl/igdd_pkg.sv
// Shared types, constants and fp32 helper functions for the int4 dequant dot block.
`default_nettype none
package igdd_pkg;

  typedef struct packed {
    logic [31:0] act_bits;
    logic [3:0]  weight_code;
    logic [31:0] scale_bits;
  } igdd_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic [15:0] row_index;
    logic        last_row;
  } igdd_out_t;

  // Unrounded value: mant / 2^26 * 2^exp, or a finished special word.
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [11:0] exp;
    logic [26:0]        mant;
  } igdd_raw_t;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_FP32  = 2'd1;
  localparam logic [1:0] MODE_FP16  = 2'd2;

  localparam logic [1:0] REG_SCALE_MODE = 2'd0;
  localparam logic [1:0] REG_ROW_LENGTH = 2'd1;
  localparam logic [1:0] REG_GROUP_LEN  = 2'd2;
  localparam logic [1:0] REG_ROW_COUNT  = 2'd3;

  localparam logic       OP_MUL = 1'b0;
  localparam logic       OP_ADD = 1'b1;

  localparam logic [12:0] MAX_ROW_LENGTH = 13'd4096;
  localparam logic [31:0] FIXED_SCALE    = 32'h3C23D70A;
  localparam logic [31:0] QNAN           = 32'h7FC00000;
  localparam logic [7:0]  EXP_ALL_ONES   = 8'hFF;

  function automatic logic [4:0] lzc27(input logic [26:0] m);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && m[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] exp,
                                             input logic [26:0] m);
    logic signed [12:0] be;
    logic signed [12:0] sh;
    logic [53:0]        wide;
    logic [26:0]        mm;
    logic               inc;
    logic [30:0]        body;
    be = 13'(exp) + 13'sd127;
    mm = m;
    sh = 13'sd0;
    wide = '0;
    if (be < 13'sd1) begin
      sh = 13'sd1 - be;
      if (sh > 13'sd27) begin
        mm = {26'd0, |m};
      end else begin
        wide = {m, 27'd0} >> sh[4:0];
        mm = {wide[53:28], wide[27] | (|wide[26:0])};
      end
      be = 13'sd1;
    end
    inc = mm[2] & ((|mm[1:0]) | mm[3]);
    body = {be[7:0] - 8'd1, 23'd0} + {7'd0, mm[26:3]} + {30'd0, inc};
    if (be >= 13'sd255) begin
      return {sign, EXP_ALL_ONES, 23'd0};
    end
    return {sign, body};
  endfunction

  function automatic logic [31:0] pack_norm(input igdd_raw_t r);
    logic [4:0] lz;
    lz = lzc27(r.mant);
    if (r.spec) begin
      return r.spec_bits;
    end
    return round_pack(r.sign, r.exp - 12'(lz), r.mant << lz);
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  q;
    logic [9:0]  fr;
    ex = h[14:10];
    man = h[9:0];
    q = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) begin
        q = 4'(i);
      end
    end
    fr = man << (4'd10 - q);
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        return {h[15], 31'd0};
      end
      return {h[15], 8'(q) + 8'd103, fr, 13'd0};
    end else if (ex == 5'h1F) begin
      return {h[15], EXP_ALL_ONES, man, 13'd0};
    end
    return {h[15], 8'(ex) + 8'd112, man, 13'd0};
  endfunction

  function automatic logic [31:0] code_to_float(input logic [3:0] code);
    logic [31:0] f;
    case (code)
      4'd0:    f = 32'hC0E00000;
      4'd1:    f = 32'hC0C00000;
      4'd2:    f = 32'hC0A00000;
      4'd3:    f = 32'hC0800000;
      4'd4:    f = 32'hC0400000;
      4'd5:    f = 32'hC0000000;
      4'd6:    f = 32'hBF800000;
      4'd7:    f = 32'h00000000;
      4'd8:    f = 32'h3F800000;
      4'd9:    f = 32'h40000000;
      4'd10:   f = 32'h40400000;
      4'd11:   f = 32'h40800000;
      4'd12:   f = 32'h40A00000;
      4'd13:   f = 32'h40C00000;
      4'd14:   f = 32'h40E00000;
      default: f = 32'h41000000;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

>>> rtl/int4_group_dequant_dot.sv
// Top level of the int4 group-quantized dequantize and dot-product block.
`default_nettype none
// One matrix element per input transfer: the 4-bit weight code minus 7 is scaled by the group
// scale, multiplied by the fp32 activation and added to an fp32 accumulator, all rounded to
// nearest even. After the accept, three operations (weight times scale, activation times
// weight, accumulate) each pass through one shared fp32 unit before the next element is
// taken. At the end of a row the result register is loaded, which parts the output side
// from the input side. A write to the row length or group length register starts a
// divisibility check of the group length; no element is taken until it is done. Results
// with an infinite or NaN sum are delivered as +0.
module int4_group_dequant_dot (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire igdd_pkg::igdd_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output igdd_pkg::igdd_out_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import igdd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MW   = 3'd1;
  localparam logic [2:0] ST_WW   = 3'd2;
  localparam logic [2:0] ST_MP   = 3'd3;
  localparam logic [2:0] ST_WP   = 3'd4;
  localparam logic [2:0] ST_AD   = 3'd5;
  localparam logic [2:0] ST_WA   = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [1:0]  scale_mode_r;
  logic [12:0] row_length_r;
  logic [12:0] grp_len_r;
  logic [15:0] row_count_r;

  logic        chk_busy_r;
  logic [3:0]  chk_cnt_r;
  logic [12:0] chk_rem_r;
  logic [12:0] gs_eff_r;
  logic [12:0] rem_step;

  logic [2:0]  state_r;
  logic [31:0] x_r;
  logic [3:0]  code_r;
  logic [31:0] scale_r;
  logic [31:0] t_r;
  logic [31:0] acc_r;
  logic [11:0] eidx_r;
  logic [11:0] gpos_r;
  logic [15:0] rowc_r;
  igdd_out_t   out_r;
  logic        out_valid_r;

  logic        wr;
  logic [12:0] k_eff;
  logic [15:0] rc_eff;
  logic        in_xfer;
  logic        out_free;
  logic        fpu_go;
  logic        fpu_op;
  logic [31:0] fpu_a, fpu_b, fpu_res;
  logic [12:0] gp1;
  logic        row_end;
  logic        last;
  logic [31:0] scale_new;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_SCALE_MODE: prdata = {30'd0, scale_mode_r};
      REG_ROW_LENGTH: prdata = {19'd0, row_length_r};
      REG_GROUP_LEN:  prdata = {19'd0, grp_len_r};
      default:        prdata = {16'd0, row_count_r};
    endcase
  end

  always_comb begin
    if (row_length_r == 13'd0) begin
      k_eff = 13'd1;
    end else if (row_length_r > MAX_ROW_LENGTH) begin
      k_eff = MAX_ROW_LENGTH;
    end else begin
      k_eff = row_length_r;
    end
  end

  assign rc_eff = (row_count_r == 16'd0) ? 16'd1 : row_count_r;

  always_comb begin
    rem_step = {chk_rem_r[11:0], k_eff[chk_cnt_r]};
    if (rem_step >= grp_len_r) begin
      rem_step = rem_step - grp_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r <= MODE_FP32;
      row_length_r <= MAX_ROW_LENGTH;
      grp_len_r    <= 13'd0;
      row_count_r  <= 16'd1;
      chk_busy_r   <= 1'b0;
      chk_cnt_r    <= 4'd0;
      chk_rem_r    <= 13'd0;
      gs_eff_r     <= MAX_ROW_LENGTH;
    end else begin
      if (wr) begin
        case (paddr[3:2])
          REG_SCALE_MODE: scale_mode_r <= pwdata[1:0];
          REG_ROW_LENGTH: row_length_r <= pwdata[12:0];
          REG_GROUP_LEN:  grp_len_r    <= pwdata[12:0];
          default:        row_count_r  <= pwdata[15:0];
        endcase
      end
      if (wr && (paddr[3:2] == REG_ROW_LENGTH || paddr[3:2] == REG_GROUP_LEN)) begin
        chk_busy_r <= 1'b1;
        chk_cnt_r  <= 4'd12;
        chk_rem_r  <= 13'd0;
      end else if (chk_busy_r) begin
        chk_rem_r <= rem_step;
        chk_cnt_r <= chk_cnt_r - 4'd1;
        if (chk_cnt_r == 4'd0) begin
          chk_busy_r <= 1'b0;
          if (grp_len_r == 13'd0 || grp_len_r > k_eff || rem_step != 13'd0) begin
            gs_eff_r <= k_eff;
          end else begin
            gs_eff_r <= grp_len_r;
          end
        end
      end
    end
  end

  assign in_stall = (state_r != ST_IDLE) || chk_busy_r;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (scale_mode_r)
      MODE_FP32: scale_new = in_data.scale_bits;
      MODE_FP16: scale_new = half_to_single(in_data.scale_bits[15:0]);
      default:   scale_new = FIXED_SCALE;
    endcase
  end

  assign fpu_go = (state_r == ST_MW) || (state_r == ST_MP) || (state_r == ST_AD);
  assign fpu_op = (state_r == ST_AD) ? OP_ADD : OP_MUL;

  always_comb begin
    case (state_r)
      ST_MW: begin
        fpu_a = code_to_float(code_r);
        fpu_b = scale_r;
      end
      ST_MP: begin
        fpu_a = x_r;
        fpu_b = t_r;
      end
      default: begin
        fpu_a = acc_r;
        fpu_b = t_r;
      end
    endcase
  end

  igdd_fpu u_fpu (
    .clk (clk),
    .go  (fpu_go),
    .op  (fpu_op),
    .a   (fpu_a),
    .b   (fpu_b),
    .res (fpu_res)
  );

  assign gp1     = {1'b0, gpos_r} + 13'd1;
  assign row_end = ({1'b0, eidx_r} + 13'd1) >= k_eff;
  assign last    = ({1'b0, rowc_r} + 17'd1) >= {1'b0, rc_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eidx_r      <= 12'd0;
      gpos_r      <= 12'd0;
      rowc_r      <= 16'd0;
      acc_r       <= 32'd0;
      scale_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (gpos_r == 12'd0) begin
              scale_r <= scale_new;
            end
            state_r <= ST_MW;
          end
        end
        ST_MW: state_r <= ST_WW;
        ST_WW: state_r <= ST_MP;
        ST_MP: state_r <= ST_WP;
        ST_WP: state_r <= ST_AD;
        ST_AD: state_r <= ST_WA;
        ST_WA: begin
          acc_r  <= fpu_res;
          gpos_r <= (gp1 >= gs_eff_r) ? 12'd0 : gp1[11:0];
          if (row_end) begin
            state_r <= ST_EMIT;
          end else begin
            eidx_r  <= eidx_r + 12'd1;
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            eidx_r      <= 12'd0;
            gpos_r      <= 12'd0;
            acc_r       <= 32'd0;
            rowc_r      <= last ? 16'd0 : rowc_r + 16'd1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r    <= in_data.act_bits;
      code_r <= in_data.weight_code;
    end
    if (state_r == ST_WW || state_r == ST_WP) begin
      t_r <= fpu_res;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_r.result_bits <= (acc_r[30:23] == EXP_ALL_ONES) ? 32'd0 : acc_r;
      out_r.row_index   <= rowc_r;
      out_r.last_row    <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> rtl/igdd_fpu.sv
// Shared two-stage fp32 multiply/add unit: operate and register, then normalize and round.
`default_nettype none
module igdd_fpu (
  input  wire logic        clk,
  input  wire logic        go,
  input  wire logic        op,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      res
);
  import igdd_pkg::*;

  igdd_raw_t raw_r;
  igdd_raw_t raw_nxt;

  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        sa, sb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  logic [23:0]        ma, mb;
  logic [4:0]         lza, lzb;
  logic signed [11:0] xa, xb;
  logic [47:0]        prod;

  logic        swap;
  logic [7:0]  ebig, esml;
  logic [23:0] mbig, msml;
  logic        sbig, ssml;
  logic [7:0]  d;
  logic [53:0] wide;
  logic [26:0] mal;
  logic [27:0] sum;

  assign sa = a[31];
  assign sb = b[31];
  assign ea = a[30:23];
  assign eb = b[30:23];
  assign fa = a[22:0];
  assign fb = b[22:0];
  assign a_nan = (ea == EXP_ALL_ONES) && (fa != 23'd0);
  assign b_nan = (eb == EXP_ALL_ONES) && (fb != 23'd0);
  assign a_inf = (ea == EXP_ALL_ONES) && (fa == 23'd0);
  assign b_inf = (eb == EXP_ALL_ONES) && (fb == 23'd0);
  assign a_zero = (a[30:0] == 31'd0);
  assign b_zero = (b[30:0] == 31'd0);

  always_comb begin
    ma = {ea != 8'd0, fa};
    mb = {eb != 8'd0, fb};
    lza = lzc27({ma, 3'd0});
    lzb = lzc27({mb, 3'd0});
    xa = (ea == 8'd0) ? -12'sd126 : (12'(ea) - 12'sd127);
    xb = (eb == 8'd0) ? -12'sd126 : (12'(eb) - 12'sd127);
    prod = 48'(ma << lza) * 48'(mb << lzb);

    swap = {ea, fa} < {eb, fb};
    ebig = swap ? eb : ea;
    esml = swap ? ea : eb;
    mbig = swap ? mb : ma;
    msml = swap ? ma : mb;
    sbig = swap ? sb : sa;
    ssml = swap ? sa : sb;
    d = ((ebig == 8'd0) ? 8'd1 : ebig) - ((esml == 8'd0) ? 8'd1 : esml);
    wide = {msml, 3'd0, 27'd0} >> d[4:0];
    if (d > 8'd27) begin
      mal = {26'd0, |msml};
    end else begin
      mal = {wide[53:28], wide[27] | (|wide[26:0])};
    end
    if (sbig == ssml) begin
      sum = {1'b0, mbig, 3'd0} + {1'b0, mal};
    end else begin
      sum = {1'b0, mbig, 3'd0} - {1'b0, mal};
    end

    raw_nxt = '0;
    if (op == OP_MUL) begin
      raw_nxt.sign = sa ^ sb;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
        raw_nxt.spec = 1'b1;
        raw_nxt.spec_bits = QNAN;
      end else if (a_inf || b_inf) begin
        raw_nxt.spec = 1'b1;
        raw_nxt.spec_bits = {sa ^ sb, EXP_ALL_ONES, 23'd0};
      end else if (a_zero || b_zero) begin
        raw_nxt.spec = 1'b1;
        raw_nxt.spec_bits = {sa ^ sb, 31'd0};
      end else if (prod[47]) begin
        raw_nxt.exp = xa - 12'(lza) + xb - 12'(lzb) + 12'sd1;
        raw_nxt.mant = {prod[47:22], |prod[21:0]};
      end else begin
        raw_nxt.exp = xa - 12'(lza) + xb - 12'(lzb);
        raw_nxt.mant = {prod[46:21], |prod[20:0]};
      end
    end else begin
      raw_nxt.sign = sbig;
      if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
        raw_nxt.spec = 1'b1;
        raw_nxt.spec_bits = QNAN;
      end else if (a_inf || b_inf) begin
        raw_nxt.spec = 1'b1;
        raw_nxt.spec_bits = {sbig, EXP_ALL_ONES, 23'd0};
      end else if (sum == 28'd0) begin
        raw_nxt.spec = 1'b1;
        raw_nxt.spec_bits = {sa & sb, 31'd0};
      end else if (sum[27]) begin
        raw_nxt.exp = 12'((ebig == 8'd0) ? 8'd1 : ebig) - 12'sd126;
        raw_nxt.mant = {sum[27:2], |sum[1:0]};
      end else begin
        raw_nxt.exp = 12'((ebig == 8'd0) ? 8'd1 : ebig) - 12'sd127;
        raw_nxt.mant = sum[26:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      raw_r <= raw_nxt;
    end
  end

  assign res = pack_norm(raw_r);

endmodule
`default_nettype wire
